FILE: src/pnfb_pkg.sv
// shared types and constants for the packed nibble framebuffer
`timescale 1ns / 1ps
package pnfb_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIM_W = 12;
	localparam int PITCH_W = DIM_W - 1;
	localparam int PROD_W = DIM_W + PITCH_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int PNFB_STORE_BYTES = 262144;

	localparam logic [DIM_W-1:0] PANEL_WIDTH_RST = 12'd960;
	localparam logic [DIM_W-1:0] PANEL_HEIGHT_RST = 12'd540;

	localparam logic [1:0] FUNC_DRAW = 2'd0;
	localparam logic [1:0] FUNC_TAKE = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [1:0] CFG_PANEL_WIDTH = 2'd0;
	localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd1;

	typedef struct packed {
		logic [1:0] func;
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
		logic [3:0] gray;
	} pnfb_cmd_t;

	typedef struct packed {
		logic accepted;
		logic [11:0] dirty_min_x;
		logic [11:0] dirty_min_y;
		logic [10:0] dirty_max_x;
		logic [10:0] dirty_max_y;
		logic [7:0] packed_byte;
	} pnfb_res_t;

	typedef struct packed {
		logic [DIM_W-1:0] min_x;
		logic [DIM_W-1:0] min_y;
		logic [DIM_W-1:0] max_x;
		logic [DIM_W-1:0] max_y;
	} pnfb_bounds_t;

	typedef struct packed {
		logic draw;
		logic take;
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
	} pnfb_bupd_t;

endpackage

FILE: src/pnfb_store.sv
// byte store with one read and one write port and a clearing sweep after reset
`timescale 1ns / 1ps
module pnfb_store import pnfb_pkg::*; #(
	parameter int STORE_BYTES = PNFB_STORE_BYTES,
	parameter int ADDR_W = $clog2(STORE_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	output logic              clearing
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rd_q;
	logic clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0] mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// the sweep owns the write port until it is done
	always_comb begin
		mem_we = clearing_q | wr_en;
		mem_waddr = clearing_q ? clr_addr_q : wr_addr;
		mem_wdata = clearing_q ? 8'h00 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign clearing = clearing_q;

endmodule

FILE: src/pnfb_bounds.sv
// dirty rectangle registers with their widen and take logic
`timescale 1ns / 1ps
module pnfb_bounds import pnfb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] panel_width,
	input  logic [DIM_W-1:0] panel_height,
	input  pnfb_bupd_t       upd,
	output pnfb_bounds_t     cur,
	output pnfb_bounds_t     widened
);

	pnfb_bounds_t bnd_q;

	always_comb begin
		widened = bnd_q;
		if (upd.x > bnd_q.max_x) widened.max_x = upd.x;
		if (upd.y > bnd_q.max_y) widened.max_y = upd.y;
		if (upd.x < bnd_q.min_x) widened.min_x = upd.x;
		if (upd.y < bnd_q.min_y) widened.min_y = upd.y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_q.min_x <= PANEL_WIDTH_RST;
			bnd_q.min_y <= PANEL_HEIGHT_RST;
			bnd_q.max_x <= '0;
			bnd_q.max_y <= '0;
		end else if (upd.take) begin
			bnd_q.min_x <= panel_width;
			bnd_q.min_y <= panel_height;
			bnd_q.max_x <= '0;
			bnd_q.max_y <= '0;
		end else if (upd.draw) begin
			bnd_q <= widened;
		end
	end

	assign cur = bnd_q;

endmodule

FILE: src/packed_nibble_framebuffer_dirty_rect_unit.sv
// 4bpp packed framebuffer with dirty rectangle tracking, top level
// each command passes the calc, addr and done states; done registers its result word
// the next command is taken only in idle, after the address multiply, read and write back
// a held result word does not block the next command until its write-back cycle
// reset: bounds and panel size to defaults, then a sweep over all STORE_BYTES bytes
// (262144 by default) zeroes the store; commands wait for it, config writes do not
`timescale 1ns / 1ps
module packed_nibble_framebuffer_dirty_rect_unit import pnfb_pkg::*; #(
	parameter int STORE_BYTES = PNFB_STORE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  pnfb_cmd_t   cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output pnfb_res_t   res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam logic [SUM_W-1:0] STORE_LIMIT = SUM_W'(STORE_BYTES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_ADDR = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	pnfb_cmd_t cmd_q;
	logic [DIM_W-1:0] panel_width_q;
	logic [DIM_W-1:0] panel_height_q;
	logic on_panel_s1;
	logic [PROD_W-1:0] prod_s1;
	logic hit_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic res_valid_q;
	pnfb_res_t res_q;

	logic clearing;
	logic [7:0] rd_data;
	logic [DIM_W-1:0] x_u;
	logic [DIM_W-1:0] y_u;
	logic on_panel;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0] byte_addr;
	logic finish;
	logic wr_en;
	logic [7:0] wr_data;
	pnfb_bupd_t upd;
	pnfb_bounds_t bnd_cur;
	pnfb_bounds_t bnd_wide;
	pnfb_bounds_t bnd_out;
	pnfb_res_t res_nxt;

	assign cmd_ready = (state_q == ST_IDLE) && !clearing;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q <= PANEL_WIDTH_RST;
			panel_height_q <= PANEL_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PANEL_WIDTH: panel_width_q <= cfg_data;
				CFG_PANEL_HEIGHT: panel_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign x_u = $unsigned(cmd_q.x_coord);
	assign y_u = $unsigned(cmd_q.y_coord);
	assign on_panel = !cmd_q.x_coord[COORD_BITS-1] && !cmd_q.y_coord[COORD_BITS-1]
		&& (x_u < panel_width_q) && (y_u < panel_height_q);
	// row pitch rounds down for an odd width
	assign prod = y_u * panel_width_q[DIM_W-1:1];
	assign byte_addr = {1'b0, prod_s1} + SUM_W'(x_u[DIM_W-1:1]);

	assign finish = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd_valid && cmd_ready) state_q <= ST_CALC;
				ST_CALC: state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_DONE;
				ST_DONE: if (finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_CALC) begin
			on_panel_s1 <= on_panel;
			prod_s1 <= prod;
		end
		if (state_q == ST_ADDR) begin
			hit_s2 <= on_panel_s1 && (byte_addr < STORE_LIMIT);
			addr_s2 <= byte_addr[ADDR_W-1:0];
		end
	end

	// even column in the high nibble
	assign wr_data = x_u[0] ? {rd_data[7:4], cmd_q.gray} : {cmd_q.gray, rd_data[3:0]};
	assign wr_en = finish && hit_s2 && (cmd_q.func == FUNC_DRAW);

	pnfb_store #(
		.STORE_BYTES(STORE_BYTES),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(state_q == ST_ADDR),
		.rd_addr(byte_addr[ADDR_W-1:0]),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(addr_s2),
		.wr_data(wr_data),
		.clearing(clearing)
	);

	always_comb begin
		upd.draw = wr_en;
		upd.take = finish && (cmd_q.func == FUNC_TAKE);
		upd.x = x_u;
		upd.y = y_u;
	end

	pnfb_bounds u_bounds (
		.clk(clk),
		.arst_n(arst_n),
		.panel_width(panel_width_q),
		.panel_height(panel_height_q),
		.upd(upd),
		.cur(bnd_cur),
		.widened(bnd_wide)
	);

	// a draw that lands reports the bounds after the update, everything else the current ones
	assign bnd_out = upd.draw ? bnd_wide : bnd_cur;

	always_comb begin
		res_nxt.accepted = hit_s2 && (cmd_q.func == FUNC_DRAW || cmd_q.func == FUNC_READ);
		res_nxt.dirty_min_x = bnd_out.min_x;
		res_nxt.dirty_min_y = bnd_out.min_y;
		res_nxt.dirty_max_x = bnd_out.max_x[10:0];
		res_nxt.dirty_max_y = bnd_out.max_y[10:0];
		res_nxt.packed_byte = (hit_s2 && cmd_q.func == FUNC_READ) ? rd_data : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

FILE: bench/tb.sv
// testbench for the packed nibble framebuffer with dirty rectangle tracking
`timescale 1ns / 1ps
module tb;
	import pnfb_pkg::*;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 800000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	pnfb_cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	pnfb_res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_PANEL_WIDTH;
	logic [11:0] cfg_data = '0;

	packed_nibble_framebuffer_dirty_rect_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow framebuffer: panel size, dirty bounds and the bytes written so far
	int unsigned fb_w = PANEL_WIDTH_RST;
	int unsigned fb_h = PANEL_HEIGHT_RST;
	int unsigned lo_x = PANEL_WIDTH_RST;
	int unsigned lo_y = PANEL_HEIGHT_RST;
	int unsigned hi_x = 0;
	int unsigned hi_y = 0;
	logic [7:0] fb_bytes [int unsigned];

	pnfb_res_t owed_res[$];
	int drawn_x[$];
	int drawn_y[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int hold_cnt = 0;
	int calm_left = 0;
	logic calm = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// stretches where neither side idles
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm <= ($urandom_range(0, 3) == 0);
			calm_left = $urandom_range(50, 400);
		end else begin
			calm_left--;
		end
	end

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit fb_locate(int sx, int sy, output int unsigned addr);
		addr = 0;
		if (sx < 0 || sy < 0)
			return 1'b0;
		if (sx >= fb_w || sy >= fb_h)
			return 1'b0;
		addr = sy * (fb_w >> 1) + (sx >> 1);
		return addr < PNFB_STORE_BYTES;
	endfunction

	function automatic pnfb_res_t shadow_apply(pnfb_cmd_t c);
		pnfb_res_t r;
		int sx;
		int sy;
		int unsigned addr;
		logic [7:0] old;
		r = '0;
		sx = $signed(c.x_coord);
		sy = $signed(c.y_coord);
		old = 8'h00;
		case (c.func)
			FUNC_DRAW: begin
				if (fb_locate(sx, sy, addr)) begin
					if (sx > hi_x) hi_x = sx;
					if (sy > hi_y) hi_y = sy;
					if (sx < lo_x) lo_x = sx;
					if (sy < lo_y) lo_y = sy;
					if (fb_bytes.exists(addr))
						old = fb_bytes[addr];
					// even column lives in the high nibble
					if (sx[0])
						fb_bytes[addr] = {old[7:4], c.gray};
					else
						fb_bytes[addr] = {c.gray, old[3:0]};
					r.accepted = 1'b1;
				end
			end
			FUNC_READ: begin
				if (fb_locate(sx, sy, addr)) begin
					r.accepted = 1'b1;
					if (fb_bytes.exists(addr))
						r.packed_byte = fb_bytes[addr];
				end
			end
			default: ;
		endcase
		r.dirty_min_x = 12'(lo_x);
		r.dirty_min_y = 12'(lo_y);
		r.dirty_max_x = 11'(hi_x);
		r.dirty_max_y = 11'(hi_y);
		// take reports the old bounds, then restarts them
		if (c.func == FUNC_TAKE) begin
			hi_x = 0;
			hi_y = 0;
			lo_x = fb_w;
			lo_y = fb_h;
		end
		return r;
	endfunction

	function automatic void cmp_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	function automatic void check_res(pnfb_res_t got);
		pnfb_res_t want;
		if (owed_res.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: result word with none expected: %h", got);
			return;
		end
		want = owed_res.pop_front();
		cmp_field("accepted", want.accepted, got.accepted);
		cmp_field("dirty_min_x", want.dirty_min_x, got.dirty_min_x);
		cmp_field("dirty_min_y", want.dirty_min_y, got.dirty_min_y);
		cmp_field("dirty_max_x", want.dirty_max_x, got.dirty_max_x);
		cmp_field("dirty_max_y", want.dirty_max_y, got.dirty_max_y);
		cmp_field("packed_byte", want.packed_byte, got.packed_byte);
	endfunction

	always @(posedge clk) begin
		if (res_valid && res_ready)
			check_res(res);
		if (hold_cnt == 0 && $urandom_range(0, 3) == 0)
			hold_cnt = pick_gap();
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// ends a hung run; the clearing sweep after reset is the longest quiet stretch
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	function automatic pnfb_cmd_t make_cmd(logic [1:0] f, int x, int y, int g);
		pnfb_cmd_t c;
		c.func = f;
		c.x_coord = x[11:0];
		c.y_coord = y[11:0];
		c.gray = g[3:0];
		return c;
	endfunction

	// below the size capped at 2048, sometimes 0, the cap less one or the cap itself
	function automatic int pick_on(int unsigned lim);
		int unsigned m;
		int unsigned r;
		if (lim == 0)
			return $urandom_range(0, 2047);
		m = (lim > 2048) ? 2048 : lim;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return m - 1;
		if (r == 2)
			return m;
		return $urandom_range(0, m - 1);
	endfunction

	function automatic pnfb_cmd_t next_cmd();
		int unsigned r;
		int px;
		int py;
		int k;
		r = $urandom_range(0, 99);
		if (r < 10)
			return make_cmd(2'($urandom), $urandom, $urandom, $urandom);
		if (r < 17)
			return make_cmd(FUNC_TAKE, $urandom, $urandom, $urandom);
		if (r < 20)
			return make_cmd(FUNC_SPARE, $urandom, $urandom, $urandom);
		if (r < 42 && drawn_x.size() > 0) begin
			k = $urandom_range(0, drawn_x.size() - 1);
			return make_cmd(FUNC_READ, drawn_x[k], drawn_y[k], $urandom);
		end
		px = pick_on(fb_w);
		py = pick_on(fb_h);
		if (r < 48)
			return make_cmd(FUNC_READ, px, py, $urandom);
		drawn_x.push_back(px);
		drawn_y.push_back(py);
		if (drawn_x.size() > 16) begin
			void'(drawn_x.pop_front());
			void'(drawn_y.pop_front());
		end
		return make_cmd(FUNC_DRAW, px, py, $urandom);
	endfunction

	task automatic push_cmd(input pnfb_cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		owed_res.push_back(shadow_apply(c));
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (owed_res.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[11:0];
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_PANEL_WIDTH)
			fb_w = val & 32'hFFF;
		else if (idx == CFG_PANEL_HEIGHT)
			fb_h = val & 32'hFFF;
	endtask

	task automatic set_panel(input int unsigned w, input int unsigned h);
		settle();
		cfg_write(CFG_PANEL_WIDTH, w);
		cfg_write(CFG_PANEL_HEIGHT, h);
		cfg_valid <= 1'b0;
		drawn_x.delete();
		drawn_y.delete();
	endtask

	task automatic test_cleared_store();
		push_cmd(make_cmd(FUNC_READ, 0, 0, 0));
		push_cmd(make_cmd(FUNC_READ, 959, 539, 15));
		push_cmd(make_cmd(FUNC_TAKE, 0, 0, 0));
	endtask

	task automatic test_nibble_packing();
		push_cmd(make_cmd(FUNC_DRAW, 0, 0, 15));
		push_cmd(make_cmd(FUNC_DRAW, 1, 0, 10));
		push_cmd(make_cmd(FUNC_READ, 1, 0, 0));
		push_cmd(make_cmd(FUNC_DRAW, 959, 539, 0));
		push_cmd(make_cmd(FUNC_DRAW, 958, 539, 15));
		push_cmd(make_cmd(FUNC_READ, 958, 539, 0));
		push_cmd(make_cmd(FUNC_DRAW, 0, 0, 0));
		push_cmd(make_cmd(FUNC_READ, 0, 0, 15));
	endtask

	task automatic test_off_panel();
		push_cmd(make_cmd(FUNC_DRAW, 960, 0, 7));
		push_cmd(make_cmd(FUNC_DRAW, 0, 540, 7));
		push_cmd(make_cmd(FUNC_DRAW, -1, 5, 7));
		push_cmd(make_cmd(FUNC_DRAW, 5, -2048, 7));
		push_cmd(make_cmd(FUNC_DRAW, 2047, 2047, 7));
		push_cmd(make_cmd(FUNC_READ, -1, -1, 0));
		push_cmd(make_cmd(FUNC_READ, 960, 539, 0));
	endtask

	task automatic test_take_and_spare();
		push_cmd(make_cmd(FUNC_SPARE, -7, 100, 9));
		push_cmd(make_cmd(FUNC_TAKE, 2047, -2048, 15));
		push_cmd(make_cmd(FUNC_TAKE, 0, 0, 0));
		push_cmd(make_cmd(FUNC_SPARE, 3, 3, 3));
	endtask

	task automatic test_random_panel(input int unsigned w, input int unsigned h, input int n);
		set_panel(w, h);
		repeat (n) push_cmd(next_cmd());
	endtask

	// the sender holds off until the result stream has fully drained
	task automatic test_drain_pause(input int unsigned w, input int unsigned h, input int n);
		set_panel(w, h);
		repeat (n) push_cmd(next_cmd());
		cmd_valid <= 1'b0;
		do @(posedge clk); while (owed_res.size() != 0);
		repeat (n) push_cmd(next_cmd());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_store();
		test_nibble_packing();
		test_off_panel();
		test_take_and_spare();
		// wide rows: upper rows fall past the end of the store
		test_random_panel(2046, 600, 250);
		test_random_panel(7, 5, 270);
		test_random_panel(2, 1, 100);
		test_random_panel(1, 3, 40);
		test_random_panel(4095, 4095, 220);
		test_random_panel(0, 0, 50);
		test_drain_pause(64, 32, 150);
		test_random_panel(PANEL_WIDTH_RST, PANEL_HEIGHT_RST, 190);
		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
